[rtl/http_chunked_body_decoder_assert.svh]
// assertion macros used by the decoder top module
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define CHD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chunked decoder assertion failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define CHD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chunked decoder assertion failed");

`endif

[rtl/chd_pkg.sv]
package chd_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned AccW    = 25;
  localparam int unsigned LeftW   = 21;
  localparam int unsigned CountW  = 20;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OutDataW = 32;

  localparam logic [CountW-1:0] OutLimitReset = 20'd32767;
  localparam logic [AccW-1:0]   SizeMaxChunk  = 25'h0100000;

  // parse modes
  localparam logic [ModeW-1:0] ModeLine = 3'd0;
  localparam logic [ModeW-1:0] ModeSize = 3'd1;
  localparam logic [ModeW-1:0] ModeExt  = 3'd2;
  localparam logic [ModeW-1:0] ModeSzLf = 3'd3;
  localparam logic [ModeW-1:0] ModeData = 3'd4;
  localparam logic [ModeW-1:0] ModeDCr  = 3'd5;
  localparam logic [ModeW-1:0] ModeDLf  = 3'd6;
  localparam logic [ModeW-1:0] ModeDone = 3'd7;

  // status codes
  localparam logic [StatusW-1:0] ErrNone  = 3'd0;
  localparam logic [StatusW-1:0] ErrHex   = 3'd1;
  localparam logic [StatusW-1:0] ErrNoDig = 3'd2;
  localparam logic [StatusW-1:0] ErrBig   = 3'd3;
  localparam logic [StatusW-1:0] ErrTrunc = 3'd4;

  // character codes
  localparam logic [ByteW-1:0] ChCr   = 8'h0D;
  localparam logic [ByteW-1:0] ChLf   = 8'h0A;
  localparam logic [ByteW-1:0] ChSemi = 8'h3B;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [AccW-1:0]    size_acc;
    logic [LeftW-1:0]   data_left;
    logic [CountW-1:0]  written;
    logic [StatusW-1:0] err;
  } chd_state_t;

  typedef struct packed {
    logic               byte_valid;
    logic [ByteW-1:0]   out_byte;
    logic               end_res;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  length;
  } chd_result_t;

  // hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_decode(input logic [ByteW-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, b[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, b[3:0] + 4'd9};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/chd_step.sv]
module chd_step (
  input  chd_pkg::chd_state_t                 state_i,
  input  logic [chd_pkg::ByteW-1:0]           byte_i,
  input  logic                                last_i,
  input  logic [chd_pkg::CountW-1:0]          out_limit_i,
  output chd_pkg::chd_state_t                 state_o,
  output logic                                has_result_o,
  output chd_pkg::chd_result_t                result_o
);

  chd_pkg::chd_state_t nxt;
  logic                wrote;
  logic                skip;
  logic [4:0]          hex;
  logic [chd_pkg::AccW-1:0]    acc;
  logic [chd_pkg::LeftW-1:0]   left;
  logic [chd_pkg::StatusW-1:0] st;
  logic                is_cr;
  logic                is_lf;

  assign is_cr = (byte_i == chd_pkg::ChCr);
  assign is_lf = (byte_i == chd_pkg::ChLf);
  assign hex   = chd_pkg::hex_decode(byte_i);

  // one body byte through the parser
  always_comb begin
    nxt   = state_i;
    wrote = 1'b0;
    skip  = 1'b0;
    acc   = {state_i.size_acc[chd_pkg::AccW-5:0], hex[3:0]};
    left  = state_i.data_left - chd_pkg::LeftW'(1);
    st    = state_i.err;
    if (state_i.err == chd_pkg::ErrNone) begin
      // optional cr / lf after a size line or after payload
      case (state_i.mode)
        chd_pkg::ModeSzLf: begin
          nxt.mode = chd_pkg::ModeData;
          skip = is_lf;
        end
        chd_pkg::ModeDCr: begin
          if (is_cr) begin
            nxt.mode = chd_pkg::ModeDLf;
            skip = 1'b1;
          end else begin
            nxt.mode = chd_pkg::ModeLine;
            skip = is_lf;
          end
        end
        chd_pkg::ModeDLf: begin
          nxt.mode = chd_pkg::ModeLine;
          skip = is_lf;
        end
        default: ;
      endcase
      if (!skip) begin
        case (nxt.mode)
          chd_pkg::ModeLine, chd_pkg::ModeSize: begin
            if (is_cr || is_lf) begin
              if (nxt.mode == chd_pkg::ModeLine) begin
                nxt.err = chd_pkg::ErrNoDig;
              end else if (state_i.size_acc == '0) begin
                nxt.mode = chd_pkg::ModeDone;
              end else begin
                nxt.data_left = state_i.size_acc[chd_pkg::LeftW-1:0];
                nxt.mode = is_cr ? chd_pkg::ModeSzLf : chd_pkg::ModeData;
              end
            end else if (byte_i == chd_pkg::ChSemi) begin
              if (nxt.mode == chd_pkg::ModeLine) nxt.err = chd_pkg::ErrNoDig;
              else nxt.mode = chd_pkg::ModeExt;
            end else if (!hex[4]) begin
              nxt.err = chd_pkg::ErrHex;
            end else begin
              nxt.size_acc = acc;
              nxt.mode = chd_pkg::ModeSize;
              if (acc > chd_pkg::SizeMaxChunk) nxt.err = chd_pkg::ErrBig;
            end
          end
          chd_pkg::ModeExt: begin
            if (is_cr || is_lf) begin
              if (state_i.size_acc == '0) begin
                nxt.mode = chd_pkg::ModeDone;
              end else begin
                nxt.data_left = state_i.size_acc[chd_pkg::LeftW-1:0];
                nxt.mode = is_cr ? chd_pkg::ModeSzLf : chd_pkg::ModeData;
              end
            end
          end
          chd_pkg::ModeData: begin
            if (state_i.written < out_limit_i) begin
              nxt.written = state_i.written + chd_pkg::CountW'(1);
              wrote = 1'b1;
            end
            if (state_i.data_left != '0) nxt.data_left = left;
            if (state_i.data_left <= chd_pkg::LeftW'(1)) begin
              nxt.data_left = '0;
              nxt.size_acc = '0;
              nxt.mode = chd_pkg::ModeDCr;
            end
          end
          default: ;
        endcase
      end
    end

    // end-of-body status
    st = nxt.err;
    if (st == chd_pkg::ErrNone) begin
      if ((nxt.mode == chd_pkg::ModeSize || nxt.mode == chd_pkg::ModeExt) &&
          nxt.size_acc != '0) begin
        st = chd_pkg::ErrTrunc;
      end else if (nxt.mode == chd_pkg::ModeSzLf || nxt.mode == chd_pkg::ModeData) begin
        st = chd_pkg::ErrTrunc;
      end
    end
  end

  // result word and state handed back
  always_comb begin
    has_result_o        = wrote || last_i;
    result_o.byte_valid = wrote;
    result_o.out_byte   = wrote ? byte_i : '0;
    result_o.end_res    = last_i;
    result_o.status     = last_i ? st : chd_pkg::ErrNone;
    result_o.length     = (last_i && st != chd_pkg::ErrNone) ? '0 : nxt.written;
    state_o             = nxt;
    if (last_i) begin
      state_o = '{mode: chd_pkg::ModeLine, size_acc: '0, data_left: '0,
                  written: '0, err: chd_pkg::ErrNone};
    end
  end

endmodule

[rtl/chd_out_reg.sv]
module chd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  chd_pkg::chd_result_t result_i,
  input  logic                 ready_i,
  output logic                 free_o,
  output logic                 valid_o,
  output chd_pkg::chd_result_t result_o
);

  logic                 valid_q, valid_d;
  chd_pkg::chd_result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign result_o = res_q;

  // valid flag: set on load, cleared once the word is taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= result_i;
  end

endmodule

[rtl/http_chunked_body_decoder.sv]
// Decodes an HTTP chunked body arriving one byte per word on the slave side and
// emits one word per payload byte, plus one word on the byte flagged tlast that
// carries the status and the final length (0 on error; on error the consumer must
// drop the bytes already emitted). The block takes one word every clock cycle while
// the master side is not stalled; the whole parser update sits between the input
// register and the result register, so each byte passes both before its result word
// is valid on the master side. Bytes yielding no result (size lines, cr/lf, dropped
// payload) are absorbed. The user must write out_limit through cfg_we_i / cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
module http_chunked_body_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: out_limit
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [30:11] length
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // end_res
);

  logic                             in_valid_q, in_valid_d;
  logic [chd_pkg::ByteW-1:0]        in_byte_q;
  logic                             in_last_q;
  logic                             in_adv;
  logic                             out_free;
  logic [chd_pkg::CountW-1:0]       out_limit_q;
  chd_pkg::chd_state_t              state_q, state_d;
  logic                             has_result;
  chd_pkg::chd_result_t             step_res;
  chd_pkg::chd_result_t             out_res;

  assign in_adv        = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= chd_pkg::OutLimitReset;
    end else if (cfg_we_i) begin
      out_limit_q <= cfg_wdata_i;
    end
  end

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) in_valid_d = 1'b1;
    else if (in_adv) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // parser step
  chd_step u_step (
    .state_i      (state_q),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .out_limit_i  (out_limit_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .result_o     (step_res)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: chd_pkg::ModeLine, size_acc: '0, data_left: '0,
                   written: '0, err: chd_pkg::ErrNone};
    end else if (in_adv) begin
      state_q <= state_d;
    end
  end

  // result register
  chd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_adv && has_result),
    .result_i (step_res),
    .ready_i  (m_axis_tready),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .result_o (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.length, out_res.status, out_res.out_byte};
  assign m_axis_tuser = out_res.byte_valid;
  assign m_axis_tlast = out_res.end_res;

  `include "http_chunked_body_decoder_assert.svh"

  `CHD_ASSERT_IMPL(a_status_only_at_end, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[10:8] == chd_pkg::ErrNone)
  `CHD_ASSERT_IMPL(a_error_zero_length, m_axis_tvalid && m_axis_tdata[10:8] != chd_pkg::ErrNone, m_axis_tdata[30:11] == '0)
  `CHD_ASSERT_NEXT(a_error_sticky, state_q.err != chd_pkg::ErrNone && !(in_adv && in_last_q), state_q.err == $past(state_q.err))
  `CHD_ASSERT_NEXT(a_result_loaded, in_adv, m_axis_tvalid == $past(has_result))

endmodule
